/* hw/rtl/mvm_pkg.sv */
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared constants and types for the matrix-vector product engine.
// ----------------------------------------------------------------------------
package mvm_pkg;

  // Default sizes of the matrix store.
  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  // Width of the row and column count registers and of the loop counters.
  localparam int DIM_W = 4;

  // Width of one Q16.16 value and of one exact Q32.32 product.
  localparam int VAL_W  = 32;
  localparam int PROD_W = 2 * VAL_W;

  // At most fifteen products are summed, so four guard bits keep the sum exact.
  localparam int ACC_W = PROD_W + 4;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Configuration register indexes.
  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  // Input item kinds, carried on in_tuser.
  localparam logic FUNC_MATRIX = 1'b0;
  localparam logic FUNC_VECTOR = 1'b1;

  // Control strobes from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

/* hw/rtl/matrix_vector_multiply_top.sv */
// ----------------------------------------------------------------------------
// matrix_vector_multiply_top
// Matrix-vector product engine on signed Q16.16 values.
// ----------------------------------------------------------------------------
// Matrix entries and vector elements are loaded one item per cycle while the
// block is idle. The vector element marked with in_tlast starts the product;
// the block then stays busy and gives one result per row, or a single error
// result when the number of vector elements in the run differs from the column
// count. One shared multiplier and accumulator do all the work: each
// matrix-vector term passes through a memory read, a multiply and an
// accumulate step, and each result waits until the consumer accepts it, with
// one result held in the output register at a time.
module matrix_vector_multiply_top #(
  parameter int MAX_ROWS = mvm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [mvm_pkg::DIM_W-1:0]          cfg_data,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // row_index [2:0], col_index [5:3], value [37:6], zero [39:38]
  input  logic [mvm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func [0]
  input  logic                               in_tuser,
  input  logic                               in_tlast,
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // product [31:0], out_row [34:32], zero [39:35]
  output logic [mvm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // dim_error [0]
  output logic                               out_tuser,
  output logic                               out_tlast
);

  localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int MA_W      = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
  localparam int VA_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_RND  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  logic [mvm_pkg::DIM_W-1:0]  row_count_r, col_count_r;
  logic [mvm_pkg::DIM_W-1:0]  rows, cols;
  logic [mvm_pkg::DIM_W-1:0]  vec_rcvd_r, vec_rcvd_nxt, vec_rcvd_inc;
  logic [mvm_pkg::DIM_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic [mvm_pkg::DIM_W-1:0]  col_cnt_r, col_cnt_nxt;

  logic [2:0]                 in_row;
  logic [2:0]                 in_col;
  logic [mvm_pkg::VAL_W-1:0]  in_value;
  logic                       in_acc;

  logic [mvm_pkg::VAL_W-1:0]  mat_mem [MAT_DEPTH];
  logic [mvm_pkg::VAL_W-1:0]  vec_mem [MAX_COLS];
  logic [mvm_pkg::VAL_W-1:0]  mat_rd_r, vec_rd_r;
  logic                       mat_we, vec_we, rd_en;
  logic [MA_W-1:0]            mat_wr_addr, mat_rd_addr;
  logic [VA_W-1:0]            vec_wr_addr, vec_rd_addr;

  mvm_pkg::mac_ctrl_t         mac_ctrl;
  logic signed [mvm_pkg::VAL_W-1:0] mac_result;

  logic                       out_valid_r, out_valid_nxt;
  logic [mvm_pkg::VAL_W-1:0]  out_product_r;
  logic [2:0]                 out_row_r;
  logic                       out_err_r, out_last_r;
  logic                       load_err, load_row;

  assign in_row   = in_tdata[2:0];
  assign in_col   = in_tdata[5:3];
  assign in_value = in_tdata[37:6];
  assign in_acc   = in_tvalid & in_tready;

  // Effective dimensions: the registers clamped to 1..MAX.
  always_comb begin
    if (row_count_r == '0) begin
      rows = mvm_pkg::DIM_W'(1);
    end else if (int'(row_count_r) > MAX_ROWS) begin
      rows = mvm_pkg::DIM_W'(MAX_ROWS);
    end else begin
      rows = row_count_r;
    end
    if (col_count_r == '0) begin
      cols = mvm_pkg::DIM_W'(1);
    end else if (int'(col_count_r) > MAX_COLS) begin
      cols = mvm_pkg::DIM_W'(MAX_COLS);
    end else begin
      cols = col_count_r;
    end
  end

  assign vec_rcvd_inc = (&vec_rcvd_r) ? vec_rcvd_r : vec_rcvd_r + 1'b1;

  assign mat_we      = in_acc && (in_tuser == mvm_pkg::FUNC_MATRIX) &&
                       (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
  assign vec_we      = in_acc && (in_tuser == mvm_pkg::FUNC_VECTOR) &&
                       (int'(in_col) < MAX_COLS);
  assign mat_wr_addr = MA_W'(int'(in_row) * MAX_COLS + int'(in_col));
  assign mat_rd_addr = MA_W'(int'(row_cnt_r) * MAX_COLS + int'(col_cnt_r));
  assign vec_wr_addr = VA_W'(in_col);
  assign vec_rd_addr = VA_W'(col_cnt_r);

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_wr_addr] <= in_value;
    end
    if (rd_en) begin
      mat_rd_r <= mat_mem[mat_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[vec_wr_addr] <= in_value;
    end
    if (rd_en) begin
      vec_rd_r <= vec_mem[vec_rd_addr];
    end
  end

  mvm_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .op_a   (mat_rd_r),
    .op_b   (vec_rd_r),
    .result (mac_result)
  );

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    vec_rcvd_nxt   = vec_rcvd_r;
    row_cnt_nxt    = row_cnt_r;
    col_cnt_nxt    = col_cnt_r;
    out_valid_nxt  = out_valid_r;
    rd_en          = 1'b0;
    mac_ctrl       = '0;
    load_err       = 1'b0;
    load_row       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == mvm_pkg::FUNC_VECTOR)) begin
          vec_rcvd_nxt = vec_rcvd_inc;
          if (in_tlast) begin
            vec_rcvd_nxt = '0;
            if (vec_rcvd_inc != cols) begin
              load_err      = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = S_OUT;
            end else begin
              row_cnt_nxt    = '0;
              col_cnt_nxt    = '0;
              mac_ctrl.clear = 1'b1;
              state_nxt      = S_RD;
            end
          end
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt       = S_ACC;
      end
      S_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        if (col_cnt_r + 1'b1 == cols) begin
          state_nxt = S_RND;
        end else begin
          col_cnt_nxt = col_cnt_r + 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RND: begin
        load_row      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            row_cnt_nxt    = row_cnt_r + 1'b1;
            col_cnt_nxt    = '0;
            mac_ctrl.clear = 1'b1;
            state_nxt      = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vec_rcvd_r  <= '0;
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      row_count_r <= mvm_pkg::DIM_W'(3);
      col_count_r <= mvm_pkg::DIM_W'(3);
    end else begin
      state_r     <= state_nxt;
      vec_rcvd_r  <= vec_rcvd_nxt;
      row_cnt_r   <= row_cnt_nxt;
      col_cnt_r   <= col_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == mvm_pkg::CFG_ROW_COUNT) begin
          row_count_r <= cfg_data;
        end else begin
          col_count_r <= cfg_data;
        end
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load_err) begin
      out_product_r <= '0;
      out_row_r     <= '0;
      out_err_r     <= 1'b1;
      out_last_r    <= 1'b1;
    end else if (load_row) begin
      out_product_r <= mac_result;
      out_row_r     <= row_cnt_r[2:0];
      out_err_r     <= 1'b0;
      out_last_r    <= (row_cnt_r + 1'b1 == rows);
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_row_r, out_product_r};
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_last_r;

endmodule

/* hw/rtl/mvm_mac.sv */
// ----------------------------------------------------------------------------
// mvm_mac
// Shared multiply-accumulate unit with Q16.16 rounding and saturation.
// ----------------------------------------------------------------------------
module mvm_mac (
  input  logic                              clk,
  input  mvm_pkg::mac_ctrl_t                ctrl,
  input  logic signed [mvm_pkg::VAL_W-1:0]  op_a,
  input  logic signed [mvm_pkg::VAL_W-1:0]  op_b,
  output logic signed [mvm_pkg::VAL_W-1:0]  result
);

  localparam int SH_W = mvm_pkg::ACC_W - 16;

  logic signed [mvm_pkg::PROD_W-1:0] prod_r;
  logic signed [mvm_pkg::ACC_W-1:0]  acc_r;
  logic signed [mvm_pkg::ACC_W-1:0]  rnd;
  logic signed [SH_W-1:0]            shifted;
  logic                              fits;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + {{(mvm_pkg::ACC_W - mvm_pkg::PROD_W){prod_r[mvm_pkg::PROD_W-1]}},
                        prod_r};
    end
  end

  // Round half up to Q16.16, then clamp to the 32-bit signed range.
  always_comb begin
    rnd     = acc_r + mvm_pkg::ACC_W'(32'h0000_8000);
    shifted = rnd[mvm_pkg::ACC_W-1:16];
    fits    = (&shifted[SH_W-1:mvm_pkg::VAL_W-1]) | ~(|shifted[SH_W-1:mvm_pkg::VAL_W-1]);
    if (fits) begin
      result = shifted[mvm_pkg::VAL_W-1:0];
    end else if (shifted[SH_W-1]) begin
      result = 32'sh8000_0000;
    end else begin
      result = 32'sh7FFF_FFFF;
    end
  end

endmodule
